// ===== src/bounded_fifo_running_average_macros.svh =====
// assertion macros for the bounded fifo running average block
`ifndef BOUNDED_FIFO_RUNNING_AVERAGE_MACROS_SVH
`define BOUNDED_FIFO_RUNNING_AVERAGE_MACROS_SVH

// condition holds at every edge out of reset
`define BFRA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// trigger implies condition at the next edge
`define BFRA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/bfra_pkg.sv =====
// shared types and constants of the bounded fifo running average block
package bfra_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned RATE_MAX        = 255;
  localparam int unsigned DIV_RADIX_BITS  = 4;
  localparam int unsigned ID_W            = 10;
  localparam int unsigned RATE_W          = 8;
  localparam int unsigned STATUS_W        = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_AVERAGE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== src/bounded_fifo_running_average.sv =====
// top level of the bounded fifo running average block
//
// Input channel (in_valid_i / in_ready_o) takes one operation per transfer:
// op_i insert appends (item_id_i, rate_value_i), dropping the oldest entry
// silently when the queue is full; op_i remove pops the oldest entry.
// Output channel (out_valid_o / out_ready_i) gives exactly one result per
// operation: status average with the rounded mean rate of held entries,
// status removed with the popped id, or status empty on a remove from an
// empty queue. Unused result fields read zero.
// The entries sit in a chain of cells; a pop shifts every cell toward the
// head together. The mean comes from a divider that resolves four
// quotient bits per cycle. A remove result is registered straight from
// the idle state; an insert first waits in the division state until the
// divider is done. One operation is in flight at a time; a new transfer
// is taken once the previous result has moved into the output register.
// If the receiver stalls, a finished result waits behind the output register
// and in_ready_o stays low until the output register frees up.
// Reset empties the queue and clears the running sum.
`include "bounded_fifo_running_average_macros.svh"

module bounded_fifo_running_average #(
  parameter int unsigned QUEUE_DEPTH = bfra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [bfra_pkg::ID_W-1:0]        item_id_i,
  input  logic [bfra_pkg::RATE_W-1:0]      rate_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bfra_pkg::STATUS_W-1:0]    status_o,
  output logic [bfra_pkg::RATE_W-1:0]      average_o,
  output logic [bfra_pkg::ID_W-1:0]        removed_id_o
);
  import bfra_pkg::*;

  localparam int unsigned SumW = $clog2(QUEUE_DEPTH*RATE_MAX+1);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [STATUS_W-1:0]   res_status_q;
  logic [RATE_W-1:0]     res_avg_q;
  logic [ID_W-1:0]       res_id_q;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [RATE_W-1:0]     average_q;
  logic [ID_W-1:0]       removed_id_q;

  logic                  accept, full, empty, do_pop, load_out;
  entry_t                new_entry;
  entry_t                entries [QUEUE_DEPTH];
  cell_ctrl_t            ctrl    [QUEUE_DEPTH];
  logic                  div_done;
  logic [RATE_W-1:0]     div_avg;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);
  assign new_entry  = '{id: item_id_i, rate: rate_value_i};
  assign do_pop     = accept && (((op_i == OP_REMOVE) && !empty) ||
                                 ((op_i == OP_INSERT) && full));
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nxt;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = new_entry;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end
    assign ctrl[i].shift = do_pop;
    assign ctrl[i].load  = accept && (op_i == OP_INSERT) && !full &&
                           (count_q == CntW'(i));
    bfra_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .nxt_i   (nxt),
      .new_i   (new_entry),
      .entry_o (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept) begin
      if (op_i == OP_INSERT) begin
        if (full) begin
          sum_d = sum_q + SumW'(rate_value_i) - SumW'(entries[0].rate);
        end else begin
          sum_d   = sum_q + SumW'(rate_value_i);
          count_d = count_q + CntW'(1);
        end
      end else if (!empty) begin
        sum_d   = sum_q - SumW'(entries[0].rate);
        count_d = count_q - CntW'(1);
      end
    end
  end

  bfra_div #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (op_i == OP_INSERT)),
    .dividend_i (sum_d),
    .divisor_i  (count_d),
    .done_o     (div_done),
    .average_o  (div_avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= STATUS_AVERAGE;
      res_avg_q    <= '0;
      res_id_q     <= '0;
      status_q     <= STATUS_AVERAGE;
      average_q    <= '0;
      removed_id_q <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op_i == OP_INSERT) begin
              res_status_q <= STATUS_AVERAGE;
              res_id_q     <= '0;
              state_q      <= S_DIV;
            end else begin
              res_avg_q <= '0;
              if (empty) begin
                res_status_q <= STATUS_EMPTY;
                res_id_q     <= '0;
              end else begin
                res_status_q <= STATUS_REMOVED;
                res_id_q     <= entries[0].id;
              end
              state_q <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_avg_q <= div_avg;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            status_q     <= res_status_q;
            average_q    <= res_avg_q;
            removed_id_q <= res_id_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign average_o    = average_q;
  assign removed_id_o = removed_id_q;

  `BFRA_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "entry count above depth")
  `BFRA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "transfer taken while busy")
  `BFRA_ASSERT_ALWAYS(a_done_in_div, !div_done || (state_q == S_DIV), "divider done out of turn")
  `BFRA_ASSERT_NEXT(a_insert_divides, accept && (op_i == OP_INSERT), state_q == S_DIV,
                    "insert did not start division")

endmodule

// ===== src/bfra_cell.sv =====
// one queue cell: holds an entry, takes its neighbor's on shift or a new one on load
module bfra_cell (
  input  logic             clk_i,
  input  bfra_pkg::cell_ctrl_t ctrl_i,
  input  bfra_pkg::entry_t nxt_i,
  input  bfra_pkg::entry_t new_i,
  output bfra_pkg::entry_t entry_o
);
  import bfra_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= nxt_i;
    end else if (ctrl_i.load) begin
      entry_q <= new_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/bfra_div.sv =====
// multi-bit-per-cycle restoring divider with round-half-even of the mean
module bfra_div #(
  parameter int unsigned QUEUE_DEPTH = bfra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   start_i,
  input  logic [$clog2(QUEUE_DEPTH*bfra_pkg::RATE_MAX+1)-1:0]    dividend_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]                       divisor_i,
  output logic                                                   done_o,
  output logic [bfra_pkg::RATE_W-1:0]                            average_o
);
  import bfra_pkg::*;

  localparam int unsigned SumW  = $clog2(QUEUE_DEPTH*RATE_MAX+1);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH+1);
  localparam int unsigned Steps = (SumW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned QuoW  = Steps * DIV_RADIX_BITS;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;

  logic [QuoW-1:0]  a_q, a_d, q_q, q_d;
  logic [CntW:0]    r_q, r_d;
  logic [CntW-1:0]  div_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;
  logic [CntW+1:0]  r2, n2;
  logic             round_up;

  always_comb begin
    a_d = a_q;
    q_d = q_q;
    r_d = r_q;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r_d = {r_d[CntW-1:0], a_d[QuoW-1]};
      a_d = {a_d[QuoW-2:0], 1'b0};
      if (r_d >= {1'b0, div_q}) begin
        r_d = r_d - {1'b0, div_q};
        q_d = {q_d[QuoW-2:0], 1'b1};
      end else begin
        q_d = {q_d[QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == StepW'(Steps - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= QuoW'(dividend_i);
      q_q   <= '0;
      r_q   <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= a_d;
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign r2       = {r_q, 1'b0};
  assign n2       = (CntW+2)'(div_q);
  assign round_up = (r2 > n2) || ((r2 == n2) && q_q[0]);
  assign average_o = q_q[RATE_W-1:0] + RATE_W'(round_up);
  assign done_o    = done_q;

endmodule

// ===== test/tb_bounded_fifo_running_average.sv =====
// testbench of the bounded fifo running average block, with its scoreboard
module tb_bounded_fifo_running_average;
  timeunit 1ns;
  timeprecision 1ps;

  import bfra_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CALM_ITEMS = 250;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RATE_W-1:0]   average;
    logic [ID_W-1:0]     removed_id;
  } report_t;

  class fifo_average_board;
    entry_t      held_entries[$];
    report_t     awaited_reports[$];
    int unsigned rate_sum;
    int unsigned mismatches;

    function new();
      rate_sum = 0;
      mismatches = 0;
    endfunction

    function logic [RATE_W-1:0] rounded_mean(int unsigned sum, int unsigned n);
      int unsigned q;
      int unsigned r;
      q = sum / n;
      r = sum % n;
      if (2 * r > n || (2 * r == n && q[0])) begin
        q++;
      end
      return q[RATE_W-1:0];
    endfunction

    function void apply_op(logic op, logic [ID_W-1:0] id, logic [RATE_W-1:0] rate);
      report_t rep;
      entry_t  ent;
      rep = '0;
      if (op == OP_INSERT) begin
        if (held_entries.size() >= DEPTH) begin
          ent = held_entries.pop_front();
          rate_sum -= ent.rate;
        end
        ent.id = id;
        ent.rate = rate;
        held_entries.push_back(ent);
        rate_sum += rate;
        rep.status = STATUS_AVERAGE;
        rep.average = rounded_mean(rate_sum, held_entries.size());
      end else if (held_entries.size() == 0) begin
        rep.status = STATUS_EMPTY;
      end else begin
        ent = held_entries.pop_front();
        rate_sum -= ent.rate;
        rep.status = STATUS_REMOVED;
        rep.removed_id = ent.id;
      end
      awaited_reports.push_back(rep);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [RATE_W-1:0] avg,
                               logic [ID_W-1:0] rid);
      report_t want;
      if (awaited_reports.size() == 0) begin
        if (mismatches < 10) begin
          $display("%t unexpected result status %0d average %0d id %0d", $realtime, st, avg,
                   rid);
        end
        mismatches++;
        return;
      end
      want = awaited_reports.pop_front();
      if (st !== want.status || avg !== want.average || rid !== want.removed_id) begin
        if (mismatches < 10) begin
          $display("%t result mismatch: expected status %0d average %0d id %0d, got %0d %0d %0d",
                   $realtime, want.status, want.average, want.removed_id, st, avg, rid);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [ID_W-1:0]     item_id_i;
  logic [RATE_W-1:0]   rate_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [RATE_W-1:0]   average_o;
  logic [ID_W-1:0]     removed_id_o;

  fifo_average_board board;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  bounded_fifo_running_average #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .item_id_i   (item_id_i),
    .rate_value_i(rate_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .average_o   (average_o),
    .removed_id_o(removed_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_op(input logic op, input logic [ID_W-1:0] id,
                         input logic [RATE_W-1:0] rate);
    in_valid_i <= 1'b1;
    op_i <= op;
    item_id_i <= id;
    rate_value_i <= rate;
    do @(posedge clk_i); while (!in_ready_o);
    board.apply_op(op, id, rate);
  endtask

  task automatic maybe_gap();
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // receiver side
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(status_o, average_o, removed_id_o);
    end
  end

  initial begin
    int unsigned       n;
    int unsigned       insert_pct;
    int unsigned       guard;
    logic              op;
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;

    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_INSERT;
    item_id_i = '0;
    rate_value_i = '0;
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    insert_pct = 50;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove on empty, extremes, ties to even in both directions, overflow drop
    send_op(OP_REMOVE, 10'h3ff, 8'hff);
    maybe_gap();
    send_op(OP_INSERT, 10'h000, 8'd0);
    maybe_gap();
    send_op(OP_INSERT, 10'h3ff, 8'd1);
    maybe_gap();
    send_op(OP_REMOVE, 10'h000, 8'd0);
    maybe_gap();
    send_op(OP_INSERT, 10'h2aa, 8'd2);
    for (n = 0; n < 7; n++) begin
      maybe_gap();
      send_op(OP_INSERT, 10'h155 + ID_W'(n), 8'd255);
    end
    for (n = 0; n < 9; n++) begin
      maybe_gap();
      send_op(OP_REMOVE, ID_W'($urandom_range(0, 1023)), RATE_W'($urandom_range(0, 255)));
    end
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 30;
          1: insert_pct = 50;
          2: insert_pct = 70;
          default: insert_pct = 90;
        endcase
        case ($urandom_range(0, 2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 25;
          default: tx_idle_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 25;
          default: rx_idle_pct = 60;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      maybe_gap();
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
      id = ID_W'($urandom_range(0, 1023));
      case ($urandom_range(0, 5))
        0: rate = '0;
        1: rate = RATE_W'(RATE_MAX);
        default: rate = RATE_W'($urandom_range(0, RATE_MAX));
      endcase
      send_op(op, id, rate);
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (board.pending() == 0 && board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
